// ===== sv/itoa_pkg.sv =====
package itoa_pkg;

	localparam int WORD_WIDTH = 32;
	localparam int VALUE_W    = 32;
	localparam int NDIG       = (WORD_WIDTH * 30103) / 100000 + 1;
	localparam int DIG_IDX_W  = $clog2(NDIG);
	localparam int STEP_W     = $clog2(WORD_WIDTH);

	localparam logic [7:0] ASCII_ZERO  = 8'd48;
	localparam logic [7:0] ASCII_MINUS = 8'd45;
	localparam logic [7:0] ASCII_NINE  = 8'd57;

	typedef logic [NDIG-1:0][3:0] bcd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} conv_status_t;

endpackage

// ===== sv/itoa_bcd.sv =====
module itoa_bcd (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [itoa_pkg::WORD_WIDTH-1:0]  mag,
	output itoa_pkg::conv_status_t           status,
	output itoa_pkg::bcd_t                   digits
);
	import itoa_pkg::*;

	logic [WORD_WIDTH-1:0] shift_q;
	bcd_t                  bcd_q;
	logic [STEP_W-1:0]     cnt_q;
	logic                  busy_q;
	logic                  done_q;
	bcd_t                  adj;
	logic [NDIG*4:0]       nxt;

	// Each step adds three to every digit of five or more, then shifts in one bit.
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? (bcd_q[i] + 4'd3) : bcd_q[i];
		end
		nxt = {adj, shift_q[WORD_WIDTH-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(WORD_WIDTH - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= mag;
			bcd_q   <= '0;
		end else if (busy_q) begin
			shift_q <= {shift_q[WORD_WIDTH-2:0], 1'b0};
			bcd_q   <= nxt[NDIG*4-1:0];
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign digits      = bcd_q;

endmodule

// ===== sv/integer_to_decimal_ascii_top.sv =====
// Formats one binary word as decimal ASCII text, most significant character first, one
// character per output transaction with last set on the final one; a negative signed word
// is preceded by '-'. The magnitude is converted by a bit-serial shift-and-add-three unit
// that shifts in one bit of the word per cycle, and the characters then follow at one per
// cycle while the output is not stalled; in_stall stays high until the final character
// has been loaded into the output register, which may still be waiting while the next
// item converts.
module integer_to_decimal_ascii_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [itoa_pkg::VALUE_W-1:0]  value,
	input  logic                          operation,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    character,
	output logic                          last
);
	import itoa_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_CONV  = 4'b0010,
		S_SIGN  = 4'b0100,
		S_DIGIT = 4'b1000
	} state_t;

	state_t                state_q;
	logic                  neg_q;
	logic [DIG_IDX_W-1:0]  idx_q;
	logic                  out_valid_q;
	logic [7:0]            char_q;
	logic                  last_q;

	logic [WORD_WIDTH-1:0] word;
	logic                  negative;
	logic [WORD_WIDTH-1:0] mag;
	logic                  start;
	logic                  out_free;
	logic [DIG_IDX_W-1:0]  top_idx;
	conv_status_t          conv_status;
	bcd_t                  digits;

	always_comb begin
		word     = WORD_WIDTH'(value);
		negative = !operation && word[WORD_WIDTH-1];
		mag      = negative ? (~word + 1'b1) : word;
	end

	assign in_stall = (state_q != S_IDLE);
	assign start    = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// The highest non-zero digit, or the units digit when the magnitude is zero.
	always_comb begin
		top_idx = '0;
		for (int i = 0; i < NDIG; i++) begin
			if (digits[i] != 4'd0) begin
				top_idx = DIG_IDX_W'(i);
			end
		end
	end

	itoa_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mag    (mag),
		.status (conv_status),
		.digits (digits)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			neg_q       <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (out_free) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						neg_q   <= negative;
						state_q <= S_CONV;
					end
				end
				S_CONV: begin
					if (conv_status.done) begin
						idx_q   <= top_idx;
						state_q <= neg_q ? S_SIGN : S_DIGIT;
					end
				end
				S_SIGN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_DIGIT;
					end
				end
				S_DIGIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (idx_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == S_SIGN) begin
				char_q <= ASCII_MINUS;
				last_q <= 1'b0;
			end else if (state_q == S_DIGIT) begin
				char_q <= ASCII_ZERO + {4'd0, digits[idx_q]};
				last_q <= (idx_q == '0);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		conv_status.done |-> (state_q == S_CONV))
	else $error("Conversion finished outside the conversion state.");

	assert property (@(posedge clk) disable iff (!arst_n)
		conv_status.busy |-> (state_q == S_CONV))
	else $error("Conversion unit busy outside the conversion state.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (char_q == ASCII_MINUS ||
			(char_q >= ASCII_ZERO && char_q <= ASCII_NINE)))
	else $error("Output character is neither a digit nor a minus sign.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && char_q == ASCII_MINUS) |-> !last_q)
	else $error("A minus sign was marked as the final character.");

endmodule
